// File: design/max_heap_priority_queue_defines.svh
// Assertion macros shared by the max-heap priority queue RTL.
`ifndef MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// a must hold at every clock edge out of reset
`define MHPQ_ASSERT_ALWAYS(label, clk, rst_n, a) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a)) \
		else $error("heap queue check failed");

// b must hold in the same cycle whenever a holds
`define MHPQ_ASSERT_IMPL(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("heap queue check failed");

// b must hold in the cycle after a
`define MHPQ_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("heap queue check failed");

`else

`define MHPQ_ASSERT_ALWAYS(label, clk, rst_n, a)
`define MHPQ_ASSERT_IMPL(label, clk, rst_n, a, b)
`define MHPQ_ASSERT_NEXT(label, clk, rst_n, a, b)

`endif

`endif

// File: design/mhpq_pkg.sv
// Shared constants and codes for the max-heap priority queue.
package mhpq_pkg;

	// default sizing
	localparam int DEF_CAPACITY = 128;
	localparam int DEF_KEY_BITS = 32;

	// stream widths
	localparam int ITEM_W     = 32;
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 80;
	localparam int STAT_W     = 2;
	localparam int COUNT_W    = 8;

	// request kinds
	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_REMOVE = 1'b1;

	// result status codes
	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

endpackage

// File: design/max_heap_priority_queue.sv
// Max-heap priority queue: binary heap in a one-based key memory, sifted by a sequencer.
// One request at a time. An insert places its key in the new last slot and climbs: per
// level it reads the parent, then compares and writes, and it stops at the root or below
// a parent that is not smaller. A remove reads the last entry, loads it as the moving key
// at the root and sinks it: per level it reads both children, then compares and writes,
// and it stops at a leaf or above children that are not larger. Each level costs one
// memory read (data registered) and one compare-and-write on the single write port; the
// moving key is held in a register and written once into its final slot. Full inserts
// and empty removes go straight to the final state. The sequencer then returns to idle
// before the next request is taken, so a new request cannot start before the last is through.
// A finished result sits in the output register while the next request is accepted; a result
// still waiting holds the sequencer in its final state until it is taken.
`include "max_heap_priority_queue_defines.svh"

module max_heap_priority_queue #(
	parameter int CAPACITY = mhpq_pkg::DEF_CAPACITY,
	parameter int KEY_BITS = mhpq_pkg::DEF_KEY_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// request channel
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [mhpq_pkg::IN_DATA_W-1:0]    s_tdata,  // [31:0] item_value
	input  logic                              s_tuser,  // [0] req_type
	// result channel
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [31:0] removed_value, [63:32] top_value, [64] top_valid,
	// [72:65] entry_count, [79:73] zero
	output logic [mhpq_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic [mhpq_pkg::STAT_W-1:0]       m_tuser   // [1:0] status
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = CW + 1;
	localparam int AW = $clog2(CAPACITY);

	// sequencer states
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_UP_RD  = 3'd1;
	localparam logic [2:0] ST_UP_CMP = 3'd2;
	localparam logic [2:0] ST_RM_RD  = 3'd3;
	localparam logic [2:0] ST_RM_LD  = 3'd4;
	localparam logic [2:0] ST_DN_RD  = 3'd5;
	localparam logic [2:0] ST_DN_CMP = 3'd6;
	localparam logic [2:0] ST_FIN    = 3'd7;

	logic [2:0]                          state_q;
	logic [CW-1:0]                       count_q;
	logic [CW-1:0]                       pos_q;
	logic signed [KEY_BITS-1:0]          cur_key_q;
	logic signed [KEY_BITS-1:0]          root_q;
	logic [mhpq_pkg::ITEM_W-1:0]         removed_q;
	logic [mhpq_pkg::STAT_W-1:0]         status_q;
	logic                                m_tvalid_q;
	logic [mhpq_pkg::OUT_DATA_W-1:0]     m_tdata_q;
	logic [mhpq_pkg::STAT_W-1:0]         m_tuser_q;

	// key memory and its registered read ports
	logic signed [KEY_BITS-1:0]          heap_mem [CAPACITY];
	logic signed [KEY_BITS-1:0]          rda_q;
	logic signed [KEY_BITS-1:0]          rdb_q;
	logic                                mem_we;
	logic [AW-1:0]                       mem_waddr;
	logic signed [KEY_BITS-1:0]          mem_wdata;
	logic [AW-1:0]                       mem_raddr_a;
	logic [AW-1:0]                       mem_raddr_b;

	// position arithmetic
	logic [CW-1:0]                       pos_m1;
	logic [CW-1:0]                       parent_pos;
	logic [CW-1:0]                       parent_m1;
	logic [CW-1:0]                       last_m1;
	logic [PW-1:0]                       left_pos;
	logic [PW-1:0]                       right_pos;
	logic [PW-1:0]                       left_m1;
	logic [PW-1:0]                       count_ext;
	logic                                is_root;
	logic                                left_out;
	logic                                right_ok;

	// compare unit
	logic                                take_right;
	logic signed [KEY_BITS-1:0]          big_key;
	logic [PW-1:0]                       big_pos;
	logic                                up_go;
	logic                                dn_go;

	// key and result formatting
	logic [63:0]                         in_ext;
	logic signed [KEY_BITS-1:0]          key_in;
	logic signed [63:0]                  root_ext;
	logic [mhpq_pkg::ITEM_W-1:0]         top_word;
	logic [CW+7:0]                       cnt_ext;
	logic                                full;
	logic                                accept;
	logic                                fin_load;

	// result checks
	logic                                res_empty;
	logic                                res_counted;
	logic                                res_cleared;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign fin_load = (state_q == ST_FIN) && (!m_tvalid_q || m_tready);

	// incoming key: sign-extend from 32 bits, wrap to the key width
	assign in_ext = {{32{s_tdata[31]}}, s_tdata};
	assign key_in = in_ext[KEY_BITS-1:0];

	// root key brought to 32 bits for the result
	assign root_ext = 64'(root_q);
	assign top_word = (count_q != '0) ? root_ext[31:0] : '0;
	assign cnt_ext  = {8'b0, count_q};
	assign full     = (count_q == CW'(CAPACITY));

	// one-based positions to zero-based addresses
	assign pos_m1     = pos_q - 1'b1;
	assign parent_pos = pos_q >> 1;
	assign parent_m1  = parent_pos - 1'b1;
	assign last_m1    = count_q - 1'b1;
	assign left_pos   = {pos_q, 1'b0};
	assign right_pos  = {pos_q, 1'b1};
	assign left_m1    = left_pos - 1'b1;
	assign count_ext  = {1'b0, count_q};
	assign is_root    = (pos_q == CW'(1));
	assign left_out   = (left_pos > count_ext);
	assign right_ok   = (right_pos <= count_ext);

	// shared compare: larger child (left on tie), then against the moving key
	assign take_right = right_ok && (rdb_q > rda_q);
	assign big_key    = take_right ? rdb_q : rda_q;
	assign big_pos    = take_right ? right_pos : left_pos;
	assign dn_go      = (big_key > cur_key_q);
	assign up_go      = (cur_key_q > rda_q);

	// memory port control
	always_comb begin
		mem_we      = 1'b0;
		mem_waddr   = pos_m1[AW-1:0];
		mem_wdata   = cur_key_q;
		mem_raddr_a = parent_m1[AW-1:0];
		mem_raddr_b = left_pos[AW-1:0];
		case (state_q)
			ST_UP_RD: begin
				if (is_root)
					mem_we = 1'b1;
			end
			ST_UP_CMP: begin
				mem_we = 1'b1;
				if (up_go)
					mem_wdata = rda_q;
			end
			ST_RM_RD: begin
				mem_raddr_a = last_m1[AW-1:0];
			end
			ST_DN_RD: begin
				mem_raddr_a = left_m1[AW-1:0];
				mem_raddr_b = left_pos[AW-1:0];
				if (left_out)
					mem_we = 1'b1;
			end
			ST_DN_CMP: begin
				mem_we = 1'b1;
				if (dn_go)
					mem_wdata = big_key;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// key memory
	always_ff @(posedge clk) begin
		if (mem_we)
			heap_mem[mem_waddr] <= mem_wdata;
		rda_q <= heap_mem[mem_raddr_a];
		rdb_q <= heap_mem[mem_raddr_b];
	end

	// copy of the root entry for the result
	always_ff @(posedge clk) begin
		if (mem_we && mem_waddr == '0)
			root_q <= mem_wdata;
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else begin
			if (fin_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (s_tuser == mhpq_pkg::REQ_INSERT) begin
							if (full) begin
								state_q <= ST_FIN;
							end else begin
								count_q <= count_q + 1'b1;
								state_q <= ST_UP_RD;
							end
						end else begin
							if (count_q == '0)
								state_q <= ST_FIN;
							else
								state_q <= ST_RM_RD;
						end
					end
				end
				ST_UP_RD: begin
					state_q <= is_root ? ST_FIN : ST_UP_CMP;
				end
				ST_UP_CMP: begin
					state_q <= up_go ? ST_UP_RD : ST_FIN;
				end
				ST_RM_RD: begin
					count_q <= count_q - 1'b1;
					state_q <= ST_RM_LD;
				end
				ST_RM_LD: begin
					state_q <= ST_DN_RD;
				end
				ST_DN_RD: begin
					state_q <= left_out ? ST_FIN : ST_DN_CMP;
				end
				ST_DN_CMP: begin
					state_q <= dn_go ? ST_DN_RD : ST_FIN;
				end
				ST_FIN: begin
					if (fin_load)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// working registers of the current request
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					pos_q     <= count_q + 1'b1;
					cur_key_q <= key_in;
					if (s_tuser == mhpq_pkg::REQ_INSERT) begin
						removed_q <= '0;
						status_q  <= full ? mhpq_pkg::STAT_FULL : mhpq_pkg::STAT_OK;
					end else if (count_q == '0) begin
						removed_q <= '0;
						status_q  <= mhpq_pkg::STAT_EMPTY;
					end else begin
						removed_q <= root_ext[31:0];
						status_q  <= mhpq_pkg::STAT_OK;
					end
				end
			end
			ST_UP_CMP: begin
				if (up_go)
					pos_q <= parent_pos;
			end
			ST_RM_LD: begin
				cur_key_q <= rda_q;
				pos_q     <= CW'(1);
			end
			ST_DN_CMP: begin
				if (dn_go)
					pos_q <= big_pos[CW-1:0];
			end
			default: begin
				pos_q <= pos_q;
			end
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (fin_load) begin
			m_tuser_q <= status_q;
			m_tdata_q <= {7'b0, cnt_ext[7:0], (count_q != '0), top_word, removed_q};
		end
	end

	assign res_empty   = m_tvalid_q && (m_tuser_q == mhpq_pkg::STAT_EMPTY);
	assign res_counted = m_tvalid_q && (m_tdata_q[72:65] != 8'd0);
	assign res_cleared = (m_tdata_q[31:0] == '0) && !m_tdata_q[64];

	`MHPQ_ASSERT_ALWAYS(a_count_in_range, clk, arst_n, count_q <= CW'(CAPACITY))
	`MHPQ_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, accept, state_q != ST_IDLE)
	`MHPQ_ASSERT_IMPL(a_write_in_heap, clk, arst_n, mem_we, pos_q <= count_q || count_q == '0)
	`MHPQ_ASSERT_IMPL(a_top_valid_count, clk, arst_n, res_counted, m_tdata_q[64])
	`MHPQ_ASSERT_IMPL(a_no_remove_status_ok_empty, clk, arst_n, res_empty, res_cleared)

endmodule
